[sv/bcrs_pkg.sv]
// Shared types, widths and constants of the battery charge rate scheduler.
`timescale 1ns / 1ps

package bcrs_pkg;

   // Field widths
   localparam int MONTH_W  = 4;
   localparam int MINUTE_W = 11;
   localparam int SOC_W    = 10;
   localparam int RATE_W   = 15;
   localparam int PCT_W    = 7;
   localparam int DEC_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Derived arithmetic widths
   localparam int TEN_W  = 11;                  // ten times a percent register
   localparam int END_W  = MINUTE_W + 1;        // window end, no wrap
   localparam int GNUM_W = TEN_W + MINUTE_W;    // goal ramp dividend
   localparam int P1_W   = TEN_W + MINUTE_W;    // soc gap times length
   localparam int NUM_W  = PCT_W + P1_W + 8;    // slow rate dividend
   localparam int DEN_W  = TEN_W + END_W;       // slow rate divisor
   localparam int GQ_W   = TEN_W;               // goal ramp quotient
   localparam int GOAL_S_W = TEN_W + 2;         // signed goal before clamp

   // Shared serial divider geometry
   localparam int DIV_DVD_W = NUM_W;
   localparam int DIV_DVS_W = DEN_W;

   localparam logic [MONTH_W-1:0] MONTH_APRIL  = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_AUGUST = 4'd7;
   localparam logic [SOC_W-1:0]   GOAL_MAX     = 10'd1000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOC_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOC_MAXIMUM   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_SLOW     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_NORMAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_MINIMUM  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BEGIN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 3'd6;

   // Register reset values
   localparam logic [PCT_W-1:0]    RST_SOC_THRESHOLD = 7'd60;
   localparam logic [PCT_W-1:0]    RST_SOC_MAXIMUM   = 7'd92;
   localparam logic [PCT_W-1:0]    RST_RATE_SLOW     = 7'd10;
   localparam logic [PCT_W-1:0]    RST_RATE_NORMAL   = 7'd30;
   localparam logic [PCT_W-1:0]    RST_RATE_MINIMUM  = 7'd7;
   localparam logic [MINUTE_W-1:0] RST_WINDOW_BEGIN  = 11'd630;
   localparam logic [MINUTE_W-1:0] RST_WINDOW_LENGTH = 11'd210;

   typedef struct packed {
      logic [PCT_W-1:0]    soc_threshold;
      logic [PCT_W-1:0]    soc_maximum;
      logic [PCT_W-1:0]    rate_slow;
      logic [PCT_W-1:0]    rate_normal;
      logic [PCT_W-1:0]    rate_minimum;
      logic [MINUTE_W-1:0] window_begin;
      logic [MINUTE_W-1:0] window_length;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [DEC_W-1:0] {
      DEC_OFF_SEASON = 3'd0,
      DEC_BELOW      = 3'd1,
      DEC_AFTER      = 3'd2,
      DEC_HOLD       = 3'd3,
      DEC_PAUSE      = 3'd4,
      DEC_SLOW       = 3'd5
   } decision_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLASS,
      S_MUL,
      S_MUL2,
      S_GSTART,
      S_GWAIT,
      S_SSTART,
      S_SWAIT,
      S_DONE
   } state_type;

endpackage

[sv/bcrs_csr.sv]
// Configuration register file with write channel and reset values.
`timescale 1ns / 1ps

module bcrs_csr
   import bcrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOC_THRESHOLD: cfg_in.soc_threshold = csr_wdata[PCT_W-1:0];
            CSR_SOC_MAXIMUM:   cfg_in.soc_maximum   = csr_wdata[PCT_W-1:0];
            CSR_RATE_SLOW:     cfg_in.rate_slow     = csr_wdata[PCT_W-1:0];
            CSR_RATE_NORMAL:   cfg_in.rate_normal   = csr_wdata[PCT_W-1:0];
            CSR_RATE_MINIMUM:  cfg_in.rate_minimum  = csr_wdata[PCT_W-1:0];
            CSR_WINDOW_BEGIN:  cfg_in.window_begin  = csr_wdata[MINUTE_W-1:0];
            CSR_WINDOW_LENGTH: cfg_in.window_length = csr_wdata[MINUTE_W-1:0];
            default:           cfg_in = cfg_ff;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soc_threshold <= RST_SOC_THRESHOLD;
         cfg_ff.soc_maximum   <= RST_SOC_MAXIMUM;
         cfg_ff.rate_slow     <= RST_RATE_SLOW;
         cfg_ff.rate_normal   <= RST_RATE_NORMAL;
         cfg_ff.rate_minimum  <= RST_RATE_MINIMUM;
         cfg_ff.window_begin  <= RST_WINDOW_BEGIN;
         cfg_ff.window_length <= RST_WINDOW_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/bcrs_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bcrs_div
   import bcrs_pkg::*;
#(
   parameter int  DVD_W = DIV_DVD_W,
   parameter int  DVS_W = DIV_DVS_W,
   localparam int CNT_W = $clog2(DVD_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] steps,
   input  logic [DVD_W-1:0] dividend,  // left-aligned, steps bits used
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output div_stat_type     stat
);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic             fit;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fit   = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit into the partial remainder, subtract if it fits
         rem_in = fit ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[sv/battery_charge_rate_scheduler.sv]
// Top level of the battery charge rate scheduler: sequencer, operand prep, result register.
// Outside the cut-off window the result follows classification directly; for a slow decision
//   the goal ramp is divided, then the slow rate too unless it is latched or the ramp is flat.
// Throughput: one item at a time; the next item is taken once the result is parked in the
//   output register. The shared bit-serial divider (22 or 37 steps) sets the window cost.
// Reset: synchronous, active high; registers return to defaults, latch and SoC goal clear.
`timescale 1ns / 1ps

module battery_charge_rate_scheduler
   import bcrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // month[3:0], minute_of_day[14:4],
                                              // soc_tenths[24:15], rate_now[39:25]
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // rate_target[14:0], soc_goal_tenths[24:15],
                                              // zero fill [31:25]
   output logic [7:0]            rsp_tuser,   // decision[2:0], zero fill [7:3]
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(DIV_DVD_W + 1);

   cfg_type      cfg;
   state_type    state_ff, state_in;
   div_stat_type div_stat;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   bcrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------
   // Sample capture
   // ---------------------------------------------------------------
   logic [MONTH_W-1:0]  month_ff;
   logic [MINUTE_W-1:0] minute_ff;
   logic [SOC_W-1:0]    soc_ff;
   logic [RATE_W-1:0]   rate_now_ff;
   logic                req_fire;

   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         month_ff    <= req_tdata[3:0];
         minute_ff   <= req_tdata[14:4];
         soc_ff      <= req_tdata[24:15];
         rate_now_ff <= req_tdata[39:25];
      end
   end

   // ---------------------------------------------------------------
   // Classification and first-level operands (S_CLASS)
   // ---------------------------------------------------------------
   logic [TEN_W-1:0]  thr10, thr1_10, max10, d10, e_abs;
   logic [PCT_W-1:0]  d_abs;
   logic              d_neg, e_neg;
   logic [END_W-1:0]  win_end, em;
   logic [MINUTE_W-1:0] mb;
   decision_type      dec;

   always_comb begin
      thr10   = TEN_W'(cfg.soc_threshold) * TEN_W'(10);
      thr1_10 = (TEN_W'(cfg.soc_threshold) + TEN_W'(1)) * TEN_W'(10);
      max10   = TEN_W'(cfg.soc_maximum) * TEN_W'(10);
      win_end = END_W'(cfg.window_begin) + END_W'(cfg.window_length);
      d_neg   = cfg.soc_maximum < cfg.soc_threshold;
      d_abs   = d_neg ? cfg.soc_threshold - cfg.soc_maximum
                      : cfg.soc_maximum - cfg.soc_threshold;
      d10     = TEN_W'(d_abs) * TEN_W'(10);
      e_neg   = TEN_W'(soc_ff) > max10;
      e_abs   = e_neg ? TEN_W'(soc_ff) - max10 : max10 - TEN_W'(soc_ff);
      mb      = minute_ff - cfg.window_begin;
      em      = win_end - END_W'(minute_ff);
      priority if (month_ff < MONTH_APRIL || month_ff > MONTH_AUGUST) begin
         dec = DEC_OFF_SEASON;
      end else if (TEN_W'(soc_ff) < thr10) begin
         dec = DEC_BELOW;
      end else if (END_W'(minute_ff) >= win_end) begin
         dec = DEC_AFTER;
      end else if (minute_ff < cfg.window_begin) begin
         dec = (TEN_W'(soc_ff) >= thr1_10) ? DEC_PAUSE : DEC_HOLD;
      end else begin
         dec = DEC_SLOW;
      end
   end

   decision_type      dec_ff;
   logic [TEN_W-1:0]  thr10_ff, d10_ff, e_abs_ff;
   logic              d_neg_ff, e_neg_ff, equal_ff;
   logic [MINUTE_W-1:0] mb_ff;
   logic [END_W-1:0]  em_ff;
   logic [GNUM_W-1:0] gnum_ff;
   logic [P1_W-1:0]   p1_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [NUM_W-1:0]  num_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_CLASS) begin
         dec_ff   <= dec;
         thr10_ff <= thr10;
         d10_ff   <= d10;
         d_neg_ff <= d_neg;
         e_abs_ff <= e_abs;
         e_neg_ff <= e_neg;
         equal_ff <= cfg.soc_maximum == cfg.soc_threshold;
         mb_ff    <= mb;
         em_ff    <= em;
      end
      // one multiplier per product, registered before the next
      if (state_ff == S_MUL) begin
         gnum_ff <= GNUM_W'(d10_ff) * GNUM_W'(mb_ff);
         p1_ff   <= P1_W'(e_abs_ff) * P1_W'(cfg.window_length);
         den_ff  <= DEN_W'(d10_ff) * DEN_W'(em_ff);
      end
      if (state_ff == S_MUL2) begin
         num_ff <= {(NUM_W - 8)'(cfg.rate_slow) * (NUM_W - 8)'(p1_ff), 8'b0};
      end
   end

   // ---------------------------------------------------------------
   // Shared serial divider
   // ---------------------------------------------------------------
   logic                 div_start;
   logic [CNT_W-1:0]     div_steps;
   logic [DIV_DVD_W-1:0] div_dividend;
   logic [DIV_DVS_W-1:0] div_divisor;
   logic [DIV_DVD_W-1:0] div_quo;

   bcrs_div #(
      .DVD_W (DIV_DVD_W),
      .DVS_W (DIV_DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // ---------------------------------------------------------------
   // Goal ramp and slow rate finishing
   // ---------------------------------------------------------------
   logic signed [GOAL_S_W-1:0] goal_s;
   logic [SOC_W-1:0]           goal_sat;
   logic [RATE_W-1:0]          rate_lo, rate_hi, slow_clamped;

   assign rate_lo = {cfg.rate_minimum, 8'b0};
   assign rate_hi = {cfg.rate_normal, 8'b0};

   always_comb begin
      // truncate toward zero: subtract the magnitude quotient for a falling ramp
      goal_s = d_neg_ff
             ? $signed({2'b0, thr10_ff}) - $signed({2'b0, div_quo[GQ_W-1:0]})
             : $signed({2'b0, thr10_ff}) + $signed({2'b0, div_quo[GQ_W-1:0]});
      priority if (goal_s < 0) begin
         goal_sat = '0;
      end else if (goal_s > $signed(GOAL_S_W'(GOAL_MAX))) begin
         goal_sat = GOAL_MAX;
      end else begin
         goal_sat = goal_s[SOC_W-1:0];
      end
      // opposite signs give a non-positive quotient, which clamps to the minimum
      priority if (e_neg_ff ^ d_neg_ff) begin
         slow_clamped = rate_lo;
      end else if (div_quo < DIV_DVD_W'(rate_lo)) begin
         slow_clamped = rate_lo;
      end else if (div_quo > DIV_DVD_W'(rate_hi)) begin
         slow_clamped = rate_hi;
      end else begin
         slow_clamped = div_quo[RATE_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   logic              latched_ff, latched_in;
   logic [RATE_W-1:0] slow_ff, slow_in;
   logic [SOC_W-1:0]  goal_ff, goal_in;
   logic              rsp_valid_ff;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_fire) state_in = S_CLASS;
         S_CLASS:  state_in = (dec == DEC_SLOW) ? S_MUL : S_DONE;
         S_MUL:    state_in = S_MUL2;
         S_MUL2:   state_in = S_GSTART;
         S_GSTART: state_in = S_GWAIT;
         S_GWAIT: begin
            if (div_stat.done) begin
               state_in = (latched_ff || equal_ff) ? S_DONE : S_SSTART;
            end
         end
         S_SSTART: state_in = S_SWAIT;
         S_SWAIT:  if (div_stat.done) state_in = S_DONE;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------
   logic out_load;

   always_comb begin
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_steps    = CNT_W'(GNUM_W);
      div_dividend = {gnum_ff, (DIV_DVD_W - GNUM_W)'(0)};
      div_divisor  = DIV_DVS_W'(cfg.window_length);
      out_load     = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_tready = 1'b1;
         S_GSTART: div_start  = 1'b1;
         S_SSTART: begin
            div_start    = 1'b1;
            div_steps    = CNT_W'(NUM_W);
            div_dividend = num_ff;
            div_divisor  = den_ff;
         end
         S_DONE:   out_load = out_free;
         default:  req_tready = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------
   // Held state: slow-rate latch and SoC goal
   // ---------------------------------------------------------------
   always_comb begin
      latched_in = latched_ff;
      slow_in    = slow_ff;
      goal_in    = goal_ff;
      if (state_ff == S_CLASS && dec == DEC_BELOW) begin
         latched_in = 1'b0;                  // drop the latch below threshold
      end
      if (state_ff == S_GWAIT && div_stat.done) begin
         goal_in = goal_sat;
         if (!latched_ff && equal_ff) begin
            latched_in = 1'b1;               // flat ramp saturates to normal
            slow_in    = rate_hi;
         end
      end
      if (state_ff == S_SWAIT && div_stat.done) begin
         latched_in = 1'b1;
         slow_in    = slow_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         latched_ff <= 1'b0;
         slow_ff    <= '0;
         goal_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         latched_ff <= latched_in;
         slow_ff    <= slow_in;
         goal_ff    <= goal_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic [RATE_W-1:0] target;
   logic [RATE_W-1:0] rsp_target_ff;
   logic [SOC_W-1:0]  rsp_goal_ff;
   decision_type      rsp_dec_ff;

   always_comb begin
      unique case (dec_ff)
         DEC_OFF_SEASON: target = rate_now_ff;
         DEC_BELOW:      target = rate_hi;
         DEC_AFTER:      target = rate_hi;
         DEC_HOLD:       target = rate_now_ff;
         DEC_PAUSE:      target = '0;
         DEC_SLOW: begin
            // keep the current rate when the whole percent already matches
            target = (rate_now_ff[RATE_W-1:8] != slow_ff[RATE_W-1:8]) ? slow_ff
                                                                       : rate_now_ff;
         end
         default:        target = rate_now_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_target_ff <= target;
         rsp_goal_ff   <= goal_ff;
         rsp_dec_ff    <= dec_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_goal_ff, rsp_target_ff};
   assign rsp_tuser  = {5'b0, rsp_dec_ff};

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_div_busy_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == S_GWAIT || state_ff == S_SWAIT))
      else $error("divider running outside a wait state");

   a_slow_div_unlatched : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SSTART || state_ff == S_SWAIT) |-> !latched_ff)
      else $error("slow rate recomputed while latched");

   a_pause_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[DEC_W-1:0] == DEC_PAUSE) |-> rsp_tdata[RATE_W-1:0] == '0)
      else $error("pause result with nonzero rate");

   a_load_clears_busy : assert property (@(posedge clock) disable iff (reset)
      out_load |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("result load did not return to idle");

endmodule
